[rtl/pbr_pkg.sv]
// ----------------------------------------------------------------------------
// pbr_pkg: shared constants, types and tables for point bearing and range
// fixed-point formats, the arctangent table and the pipeline control struct
// ----------------------------------------------------------------------------
package pbr_pkg;

    // parameter defaults
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int COORD_BITS_DEF   = 20;

    // fraction bits added to the coordinate differences
    localparam int GUARD      = 16;
    // headroom of the datapath beyond the coordinate width
    localparam int DATA_EXTRA = GUARD + 4;

    // field widths
    localparam int OFFSET_W  = 20;
    localparam int BEARING_W = 15;
    localparam int DIST_W    = 22;

    // angle accumulator in 1/16384 degree
    localparam int ANGLE_W   = 24;
    localparam int TAB_LEN   = 24;
    localparam int DEG_Q     = 16384;
    localparam int ANGLE_90  = 90 * DEG_Q;
    localparam int ANGLE_450 = 450 * DEG_Q;

    // 1/K in Q30
    localparam int INV_GAIN_W = 30;
    localparam logic [INV_GAIN_W-1:0] INV_GAIN_Q30 = 30'd652032874;

    // bearing codes in 1/64 degree
    localparam logic [BEARING_W-1:0] BEARING_EQUAL = 15'd5760;
    localparam logic [BEARING_W-1:0] FULL_TURN_64  = 15'd23040;

    typedef struct packed {
        logic valid;
        logic zero;
    } pbr_ctl_t;

    // atan(2^-idx) in 1/16384 degree, rounded to nearest
    function automatic logic signed [ANGLE_W-1:0] angle_tab(input int idx);
        logic signed [ANGLE_W-1:0] val;
        case (idx)
            0:       val = 24'sd737280;
            1:       val = 24'sd435242;
            2:       val = 24'sd229970;
            3:       val = 24'sd116736;
            4:       val = 24'sd58595;
            5:       val = 24'sd29326;
            6:       val = 24'sd14667;
            7:       val = 24'sd7334;
            8:       val = 24'sd3667;
            9:       val = 24'sd1833;
            10:      val = 24'sd917;
            11:      val = 24'sd458;
            12:      val = 24'sd229;
            13:      val = 24'sd115;
            14:      val = 24'sd57;
            15:      val = 24'sd29;
            16:      val = 24'sd14;
            17:      val = 24'sd7;
            18:      val = 24'sd4;
            19:      val = 24'sd2;
            20:      val = 24'sd1;
            default: val = 24'sd0;
        endcase
        return val;
    endfunction

endpackage

[rtl/pbr_prep.sv]
// ----------------------------------------------------------------------------
// pbr_prep: input stages of the bearing and range pipeline
// forms the differences, then scales and turns them into the right half plane
// ----------------------------------------------------------------------------
module pbr_prep #(
    parameter int COORD_BITS = pbr_pkg::COORD_BITS_DEF,
    parameter int W          = pbr_pkg::COORD_BITS_DEF + pbr_pkg::DATA_EXTRA
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [COORD_BITS-1:0]        from_x,
    input  logic signed [COORD_BITS-1:0]        from_y,
    input  logic signed [COORD_BITS-1:0]        to_x,
    input  logic signed [COORD_BITS-1:0]        to_y,
    input  logic [pbr_pkg::OFFSET_W-1:0]        range_offset,
    output pbr_pkg::pbr_ctl_t                   down_ctl,
    output logic signed [W-1:0]                 down_x,
    output logic signed [W-1:0]                 down_y,
    output logic signed [pbr_pkg::ANGLE_W-1:0]  down_z,
    output logic [pbr_pkg::OFFSET_W-1:0]        down_off,
    input  logic                                down_ready
);

    localparam int DX_W  = COORD_BITS + 1;
    localparam int PAD_W = W - DX_W - pbr_pkg::GUARD;

    localparam logic signed [pbr_pkg::ANGLE_W-1:0] Z_POS =
        pbr_pkg::ANGLE_W'(pbr_pkg::ANGLE_90);
    localparam logic signed [pbr_pkg::ANGLE_W-1:0] Z_NEG =
        pbr_pkg::ANGLE_W'(-pbr_pkg::ANGLE_90);

    // stage 1: differences
    pbr_pkg::pbr_ctl_t            ctl1_reg;
    logic signed [DX_W-1:0]       dx_reg, dx_next;
    logic signed [DX_W-1:0]       dy_reg, dy_next;
    logic [pbr_pkg::OFFSET_W-1:0] off1_reg;
    logic                         zero_next;

    // stage 2: scaled, pre-rotated vector
    pbr_pkg::pbr_ctl_t                   ctl2_reg;
    logic signed [W-1:0]                 x_reg, x_next;
    logic signed [W-1:0]                 y_reg, y_next;
    logic signed [pbr_pkg::ANGLE_W-1:0]  z_reg, z_next;
    logic [pbr_pkg::OFFSET_W-1:0]        off2_reg;

    logic                en1, en2;
    logic signed [W-1:0] dx_w, dy_w;

    assign en2      = !ctl2_reg.valid || down_ready;
    assign en1      = !ctl1_reg.valid || en2;
    assign in_ready = en1;

    always_comb
    begin
        dx_next   = {to_x[COORD_BITS-1], to_x} - {from_x[COORD_BITS-1], from_x};
        dy_next   = {to_y[COORD_BITS-1], to_y} - {from_y[COORD_BITS-1], from_y};
        zero_next = (to_x == from_x) && (to_y == from_y);
    end

    always_comb
    begin
        dx_w = {{PAD_W{dx_reg[DX_W-1]}}, dx_reg, {pbr_pkg::GUARD{1'b0}}};
        dy_w = {{PAD_W{dy_reg[DX_W-1]}}, dy_reg, {pbr_pkg::GUARD{1'b0}}};
        if (!dx_reg[DX_W-1])
        begin
            x_next = dx_w;
            y_next = dy_w;
            z_next = '0;
        end
        else if (!dy_reg[DX_W-1])
        begin
            x_next = dy_w;
            y_next = -dx_w;
            z_next = Z_POS;
        end
        else
        begin
            x_next = -dy_w;
            y_next = dx_w;
            z_next = Z_NEG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else
        begin
            if (en1)
            begin
                ctl1_reg.valid <= in_valid;
                ctl1_reg.zero  <= zero_next;
            end
            if (en2)
            begin
                ctl2_reg <= ctl1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
            off1_reg <= range_offset;
        end
        if (en2 && ctl1_reg.valid)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            off2_reg <= off1_reg;
        end
    end

    assign down_ctl = ctl2_reg;
    assign down_x   = x_reg;
    assign down_y   = y_reg;
    assign down_z   = z_reg;
    assign down_off = off2_reg;

endmodule

[rtl/pbr_cordic_stage.sv]
// ----------------------------------------------------------------------------
// pbr_cordic_stage: one registered vectoring iteration
// rotates toward y = 0 by atan(2^-IDX) and accumulates the angle
// ----------------------------------------------------------------------------
module pbr_cordic_stage #(
    parameter int W   = pbr_pkg::COORD_BITS_DEF + pbr_pkg::DATA_EXTRA,
    parameter int IDX = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pbr_pkg::pbr_ctl_t                   up_ctl,
    input  logic signed [W-1:0]                 up_x,
    input  logic signed [W-1:0]                 up_y,
    input  logic signed [pbr_pkg::ANGLE_W-1:0]  up_z,
    input  logic [pbr_pkg::OFFSET_W-1:0]        up_off,
    output logic                                up_ready,
    output pbr_pkg::pbr_ctl_t                   down_ctl,
    output logic signed [W-1:0]                 down_x,
    output logic signed [W-1:0]                 down_y,
    output logic signed [pbr_pkg::ANGLE_W-1:0]  down_z,
    output logic [pbr_pkg::OFFSET_W-1:0]        down_off,
    input  logic                                down_ready
);

    localparam logic signed [pbr_pkg::ANGLE_W-1:0] TAB = pbr_pkg::angle_tab(IDX);

    pbr_pkg::pbr_ctl_t                   ctl_reg;
    logic signed [W-1:0]                 x_reg, x_next;
    logic signed [W-1:0]                 y_reg, y_next;
    logic signed [pbr_pkg::ANGLE_W-1:0]  z_reg, z_next;
    logic [pbr_pkg::OFFSET_W-1:0]        off_reg;
    logic signed [W-1:0]                 xs, ys;

    assign up_ready = !ctl_reg.valid || down_ready;

    always_comb
    begin
        xs = up_x >>> IDX;
        ys = up_y >>> IDX;
        if (!up_y[W-1])
        begin
            x_next = up_x + ys;
            y_next = up_y - xs;
            z_next = up_z + TAB;
        end
        else
        begin
            x_next = up_x - ys;
            y_next = up_y + xs;
            z_next = up_z - TAB;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (up_ready)
        begin
            ctl_reg <= up_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_ctl.valid)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            off_reg <= up_off;
        end
    end

    assign down_ctl = ctl_reg;
    assign down_x   = x_reg;
    assign down_y   = y_reg;
    assign down_z   = z_reg;
    assign down_off = off_reg;

endmodule

[rtl/pbr_post.sv]
// ----------------------------------------------------------------------------
// pbr_post: output stages of the bearing and range pipeline
// compass conversion and rounding, gain correction, offset and saturation
// ----------------------------------------------------------------------------
module pbr_post #(
    parameter int COORD_BITS = pbr_pkg::COORD_BITS_DEF,
    parameter int W          = pbr_pkg::COORD_BITS_DEF + pbr_pkg::DATA_EXTRA
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pbr_pkg::pbr_ctl_t                   up_ctl,
    input  logic signed [W-1:0]                 up_x,
    input  logic signed [pbr_pkg::ANGLE_W-1:0]  up_z,
    input  logic [pbr_pkg::OFFSET_W-1:0]        up_off,
    output logic                                up_ready,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [pbr_pkg::BEARING_W-1:0]       bearing,
    output logic signed [pbr_pkg::DIST_W-1:0]   distance
);

    localparam int GW    = pbr_pkg::GUARD;
    localparam int KW    = pbr_pkg::INV_GAIN_W;
    localparam int UX_W  = W - 1;
    localparam int HI_W  = UX_W - GW;
    localparam int LOP_W = GW + KW;
    localparam int T_W   = HI_W + KW + 1;
    localparam int MAG_W = T_W - KW;
    localparam int DW    = (COORD_BITS + 6 > pbr_pkg::DIST_W + 1) ?
                           COORD_BITS + 6 : pbr_pkg::DIST_W + 1;
    localparam int BW    = pbr_pkg::ANGLE_W + 2;
    localparam int BU_W  = pbr_pkg::ANGLE_W;
    localparam int RND_W = BU_W + 1;
    localparam int Q_W   = RND_W - 8;

    localparam logic signed [BW-1:0] B_90  = BW'(pbr_pkg::ANGLE_90);
    localparam logic signed [BW-1:0] B_450 = BW'(pbr_pkg::ANGLE_450);
    localparam logic signed [DW-1:0] D_MAX = DW'((2 ** (pbr_pkg::DIST_W - 1)) - 1);
    localparam logic signed [DW-1:0] D_MIN = -D_MAX - DW'(1);

    pbr_pkg::pbr_ctl_t c1_reg, c2_reg, c3_reg;
    logic en1, en2, en3;

    // stage 1
    logic signed [BW-1:0]         bs, z_ext;
    logic [BU_W-1:0]              b_reg, b_next;
    logic [UX_W-1:0]              ux;
    logic [LOP_W-1:0]             lo_prod;
    logic [KW-1:0]                lo_reg, lo_next;
    logic [HI_W-1:0]              hi_reg, hi_next;
    logic [pbr_pkg::OFFSET_W-1:0] off1_reg, off2_reg;

    // stage 2
    logic [RND_W-1:0]              rnd;
    logic [Q_W-1:0]                q;
    logic [pbr_pkg::BEARING_W-1:0] bear2_reg, bear2_next;
    logic [T_W-1:0]                t;
    logic [MAG_W-1:0]              mag_reg, mag_next;

    // stage 3
    logic [MAG_W-1:0]                    mag_eff;
    logic signed [DW-1:0]                diff;
    logic [pbr_pkg::BEARING_W-1:0]       bear3_reg, bear3_next;
    logic signed [pbr_pkg::DIST_W-1:0]   dist_reg, dist_next;

    assign en3      = !c3_reg.valid || out_ready;
    assign en2      = !c2_reg.valid || en3;
    assign en1      = !c1_reg.valid || en2;
    assign up_ready = en1;

    always_comb
    begin
        z_ext = {{(BW - pbr_pkg::ANGLE_W){up_z[pbr_pkg::ANGLE_W-1]}}, up_z};
        if (z_ext > B_90)
            bs = B_450 - z_ext;
        else
            bs = B_90 - z_ext;
        b_next  = bs[BW-1] ? '0 : bs[BU_W-1:0];
        ux      = up_x[W-1] ? '0 : up_x[UX_W-1:0];
        lo_prod = LOP_W'(ux[GW-1:0]) * LOP_W'(pbr_pkg::INV_GAIN_Q30);
        lo_next = lo_prod[LOP_W-1:GW];
        hi_next = ux[UX_W-1:GW];
    end

    always_comb
    begin
        rnd = {1'b0, b_reg} + RND_W'(128);
        q   = rnd[RND_W-1:8];
        // just past 90 degrees the rounded value can reach a full turn
        if (q >= Q_W'(pbr_pkg::FULL_TURN_64))
            bear2_next = pbr_pkg::BEARING_W'(q - Q_W'(pbr_pkg::FULL_TURN_64));
        else
            bear2_next = q[pbr_pkg::BEARING_W-1:0];
        t        = T_W'(hi_reg) * T_W'(pbr_pkg::INV_GAIN_Q30) + T_W'(lo_reg);
        mag_next = t[T_W-1:KW];
    end

    always_comb
    begin
        mag_eff = c2_reg.zero ? '0 : mag_reg;
        diff    = $signed({{(DW - MAG_W){1'b0}}, mag_eff})
                - $signed({{(DW - pbr_pkg::OFFSET_W){1'b0}}, off2_reg});
        if (diff > D_MAX)
            dist_next = D_MAX[pbr_pkg::DIST_W-1:0];
        else if (diff < D_MIN)
            dist_next = D_MIN[pbr_pkg::DIST_W-1:0];
        else
            dist_next = diff[pbr_pkg::DIST_W-1:0];
        bear3_next = c2_reg.zero ? pbr_pkg::BEARING_EQUAL : bear2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
        end
        else
        begin
            if (en1)
                c1_reg <= up_ctl;
            if (en2)
                c2_reg <= c1_reg;
            if (en3)
                c3_reg <= c2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && up_ctl.valid)
        begin
            b_reg    <= b_next;
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
            off1_reg <= up_off;
        end
        if (en2 && c1_reg.valid)
        begin
            bear2_reg <= bear2_next;
            mag_reg   <= mag_next;
            off2_reg  <= off1_reg;
        end
        if (en3 && c2_reg.valid)
        begin
            bear3_reg <= bear3_next;
            dist_reg  <= dist_next;
        end
    end

    assign out_valid = c3_reg.valid;
    assign bearing   = bear3_reg;
    assign distance  = dist_reg;

endmodule

[rtl/point_bearing_and_range.sv]
// ----------------------------------------------------------------------------
// point_bearing_and_range: compass bearing and range between two points
//
// input channel (in_valid / in_ready): one transfer carries from_x, from_y,
// to_x, to_y and range_offset. output channel (out_valid / out_ready): one
// transfer carries bearing (1/64 degree, 0 along +y, clockwise) and
// distance (whole units minus range_offset, saturated, signed).
// every input transfer yields exactly one output transfer, in order.
// the path from input transfer to out_valid runs through two input
// stages, one stage per vectoring iteration and three output stages.
// throughput: one item per cycle while the receiver keeps out_ready high;
// the figure is set by the one-iteration-per-stage vectoring pipeline.
// reset clears every stage valid bit; the pipeline starts empty.
// when the receiver stalls, the output register holds its result and
// earlier stages keep advancing into empty slots; in_ready drops only
// once every stage holds an item.
// ----------------------------------------------------------------------------
module point_bearing_and_range #(
    parameter int CORDIC_STEPS = pbr_pkg::CORDIC_STEPS_DEF,
    parameter int COORD_BITS   = pbr_pkg::COORD_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [COORD_BITS-1:0]       from_x,
    input  logic signed [COORD_BITS-1:0]       from_y,
    input  logic signed [COORD_BITS-1:0]       to_x,
    input  logic signed [COORD_BITS-1:0]       to_y,
    input  logic [pbr_pkg::OFFSET_W-1:0]       range_offset,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [pbr_pkg::BEARING_W-1:0]      bearing,
    output logic signed [pbr_pkg::DIST_W-1:0]  distance
);

    // datapath width: coordinate difference, guard fraction, cordic growth
    localparam int W = COORD_BITS + pbr_pkg::DATA_EXTRA;

    // pipeline links: index k feeds vectoring iteration k
    pbr_pkg::pbr_ctl_t                   ctl  [CORDIC_STEPS+1];
    logic signed [W-1:0]                 xv   [CORDIC_STEPS+1];
    logic signed [W-1:0]                 yv   [CORDIC_STEPS+1];
    logic signed [pbr_pkg::ANGLE_W-1:0]  zv   [CORDIC_STEPS+1];
    logic [pbr_pkg::OFFSET_W-1:0]        offv [CORDIC_STEPS+1];
    logic                                rdy  [CORDIC_STEPS+1];

    // differences, scaling and half-plane turn
    pbr_prep #(
        .COORD_BITS (COORD_BITS),
        .W          (W)
    ) u_prep (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .from_x       (from_x),
        .from_y       (from_y),
        .to_x         (to_x),
        .to_y         (to_y),
        .range_offset (range_offset),
        .down_ctl     (ctl[0]),
        .down_x       (xv[0]),
        .down_y       (yv[0]),
        .down_z       (zv[0]),
        .down_off     (offv[0]),
        .down_ready   (rdy[0])
    );

    // one vectoring iteration per stage
    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_step
        pbr_cordic_stage #(
            .W   (W),
            .IDX (k)
        ) u_stage (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_ctl     (ctl[k]),
            .up_x       (xv[k]),
            .up_y       (yv[k]),
            .up_z       (zv[k]),
            .up_off     (offv[k]),
            .up_ready   (rdy[k]),
            .down_ctl   (ctl[k+1]),
            .down_x     (xv[k+1]),
            .down_y     (yv[k+1]),
            .down_z     (zv[k+1]),
            .down_off   (offv[k+1]),
            .down_ready (rdy[k+1])
        );
    end

    // compass bearing, gain-corrected range, output register
    pbr_post #(
        .COORD_BITS (COORD_BITS),
        .W          (W)
    ) u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_ctl    (ctl[CORDIC_STEPS]),
        .up_x      (xv[CORDIC_STEPS]),
        .up_z      (zv[CORDIC_STEPS]),
        .up_off    (offv[CORDIC_STEPS]),
        .up_ready  (rdy[CORDIC_STEPS]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .bearing   (bearing),
        .distance  (distance)
    );

`ifndef SYNTHESIS
    // a draining output lets the whole pipeline advance
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("in_ready low while output drains");

    // input back-pressure only when every stage is full and output stalled
    a_full_only: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("in_ready low with room in the pipeline");

    // bearing wrap leaves the value below a full turn
    a_bearing_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (bearing < pbr_pkg::FULL_TURN_64))
        else $error("bearing out of range");

    // distance never goes below minus the largest offset
    a_dist_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (distance >= -22'sd1048575))
        else $error("distance below offset floor");

    // an output stall holds the pipeline closed upstream once it is full
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_ready && !out_ready) |=> (!in_ready || out_ready))
        else $error("full pipeline opened without an output transfer");
`endif

endmodule
